// File: hdl/gpio54_pkg.sv
package gpio54_pkg;

  localparam int PIN_COUNT = 54;

  localparam int MODE_W = 2;
  localparam int INDEX_W = 6;
  localparam int WORD_W = 32;

  localparam int FSEL_W = 3;
  localparam int PULL_W = 2;
  localparam int FSEL_PER_WORD = 10;
  localparam int FSEL_WORDS = 7;
  localparam int FSEL_FIELD_W = FSEL_PER_WORD * FSEL_W;
  localparam int FSEL_PAD_W = FSEL_WORDS * FSEL_FIELD_W;

  localparam int IN_TDATA_W = ((INDEX_W + WORD_W + PIN_COUNT + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((WORD_W + 4 * PIN_COUNT + 1 + 7) / 8) * 8;

  typedef logic [PIN_COUNT-1:0] pins_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  localparam logic [INDEX_W-1:0] REG_FSEL_LAST  = 6'd6;
  localparam logic [INDEX_W-1:0] REG_SET0       = 6'd7;
  localparam logic [INDEX_W-1:0] REG_SET1       = 6'd8;
  localparam logic [INDEX_W-1:0] REG_CLR0       = 6'd10;
  localparam logic [INDEX_W-1:0] REG_CLR1       = 6'd11;
  localparam logic [INDEX_W-1:0] REG_LEV0       = 6'd13;
  localparam logic [INDEX_W-1:0] REG_LEV1       = 6'd14;
  localparam logic [INDEX_W-1:0] REG_EDS0       = 6'd16;
  localparam logic [INDEX_W-1:0] REG_EDS1       = 6'd17;
  localparam logic [INDEX_W-1:0] REG_REN0       = 6'd19;
  localparam logic [INDEX_W-1:0] REG_REN1       = 6'd20;
  localparam logic [INDEX_W-1:0] REG_FEN0       = 6'd22;
  localparam logic [INDEX_W-1:0] REG_FEN1       = 6'd23;
  localparam logic [INDEX_W-1:0] REG_HEN0       = 6'd25;
  localparam logic [INDEX_W-1:0] REG_HEN1       = 6'd26;
  localparam logic [INDEX_W-1:0] REG_LEN0       = 6'd28;
  localparam logic [INDEX_W-1:0] REG_LEN1       = 6'd29;
  localparam logic [INDEX_W-1:0] REG_PULL       = 6'd37;
  localparam logic [INDEX_W-1:0] REG_PULL_CLK0  = 6'd38;
  localparam logic [INDEX_W-1:0] REG_PULL_CLK1  = 6'd39;

  localparam logic [FSEL_W-1:0] FSEL_OUTPUT = 3'd1;
  localparam logic [PULL_W-1:0] PULL_DOWN = 2'd1;
  localparam logic [PULL_W-1:0] PULL_UP = 2'd2;

  function automatic logic [WORD_W-1:0] half_get(input pins_t v, input logic hi);
    logic [63:0] t;
    t = 64'(v);
    return hi ? t[63:32] : t[31:0];
  endfunction

  function automatic pins_t half_bits(input logic [WORD_W-1:0] d, input logic hi);
    logic [63:0] t;
    t = hi ? {d, 32'd0} : {32'd0, d};
    return t[PIN_COUNT-1:0];
  endfunction

  function automatic pins_t half_put(input pins_t v, input logic hi,
                                     input logic [WORD_W-1:0] d);
    logic [63:0] t;
    t = 64'(v);
    if (hi) begin
      t[63:32] = d;
    end else begin
      t[31:0] = d;
    end
    return t[PIN_COUNT-1:0];
  endfunction

endpackage

// File: hdl/gpio_controller_54_pin.sv
// GPIO controller for 54 pins with edge and level event detection.
// The input channel carries one transfer per bus read, bus write, pin
// sample tick or no-op; the kind of transfer travels in in_tuser. Every
// accepted transfer produces exactly one result transfer on the output
// channel, holding the read word (zero for writes, ticks and no-ops) and
// the pin drive, output enable, pull-up and pull-down vectors plus the
// event flag, all taken after the transfer's own register update.
// The result is presented in the cycle after the input transfer. Throughput
// is one transfer per cycle while the receiver keeps out_tready high, set by
// the single output register that follows the register update logic.
// The input is ready whenever the output register is empty or is being
// emptied in the same cycle, so a stalled receiver holds the result and
// stops new input after one transfer.
// Synchronous reset clears all function selects to input, the output
// latch, sampled levels, detect enables, event status and pull settings,
// and empties the output register.
module gpio_controller_54_pin (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // reg_index, write_data, pin_levels
  input  logic [gpio54_pkg::IN_TDATA_W-1:0]   in_tdata,
  // mode
  input  logic [gpio54_pkg::MODE_W-1:0]       in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // read_data, drive_levels, output_enable, pull_up_enable,
  // pull_down_enable, event_pending
  output logic [gpio54_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int PINS = gpio54_pkg::PIN_COUNT;
  localparam int IW = gpio54_pkg::INDEX_W;
  localparam int WW = gpio54_pkg::WORD_W;
  localparam int FW = gpio54_pkg::FSEL_W;
  localparam int PW = gpio54_pkg::PULL_W;
  localparam int OUT_USED = WW + 4 * PINS + 1;

  logic [PINS*FW-1:0]     fsel_r, fsel_nxt;
  logic [PINS*PW-1:0]     pull_set_r, pull_set_nxt;
  gpio54_pkg::pins_t      latch_r, latch_nxt;
  gpio54_pkg::pins_t      level_r, level_nxt;
  gpio54_pkg::pins_t      ren_r, ren_nxt;
  gpio54_pkg::pins_t      fen_r, fen_nxt;
  gpio54_pkg::pins_t      hen_r, hen_nxt;
  gpio54_pkg::pins_t      len_r, len_nxt;
  gpio54_pkg::pins_t      status_r, status_nxt;
  logic [PW-1:0]          pull_ctrl_r, pull_ctrl_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_USED-1:0]    out_data_r, out_data_nxt;

  logic                   in_fire;
  gpio54_pkg::mode_t      mode;
  logic [IW-1:0]          widx;
  logic [WW-1:0]          wdata;
  gpio54_pkg::pins_t      pins_in;
  logic                   is_write;
  logic [WW-1:0]          rd;
  logic [gpio54_pkg::FSEL_PAD_W-1:0] fsel_pad;
  gpio54_pkg::pins_t      pull_sel;
  gpio54_pkg::pins_t      ev;
  gpio54_pkg::pins_t      oe, pu, pd;

  assign in_fire = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign mode = gpio54_pkg::mode_t'(in_tuser);
  assign widx = in_tdata[IW-1:0];
  assign wdata = in_tdata[IW +: WW];
  assign pins_in = in_tdata[IW+WW +: PINS];
  assign is_write = (mode == gpio54_pkg::MODE_WRITE);
  assign fsel_pad = gpio54_pkg::FSEL_PAD_W'(fsel_r);

  always_comb begin
    rd = '0;
    if (mode == gpio54_pkg::MODE_READ) begin
      for (int i = 0; i < gpio54_pkg::FSEL_WORDS; i++) begin
        if (widx == IW'(i)) begin
          rd = WW'(fsel_pad[i*gpio54_pkg::FSEL_FIELD_W +: gpio54_pkg::FSEL_FIELD_W]);
        end
      end
      unique case (widx)
        gpio54_pkg::REG_LEV0: rd = gpio54_pkg::half_get(level_r, 1'b0);
        gpio54_pkg::REG_LEV1: rd = gpio54_pkg::half_get(level_r, 1'b1);
        gpio54_pkg::REG_EDS0: rd = gpio54_pkg::half_get(status_r, 1'b0);
        gpio54_pkg::REG_EDS1: rd = gpio54_pkg::half_get(status_r, 1'b1);
        gpio54_pkg::REG_REN0: rd = gpio54_pkg::half_get(ren_r, 1'b0);
        gpio54_pkg::REG_REN1: rd = gpio54_pkg::half_get(ren_r, 1'b1);
        gpio54_pkg::REG_FEN0: rd = gpio54_pkg::half_get(fen_r, 1'b0);
        gpio54_pkg::REG_FEN1: rd = gpio54_pkg::half_get(fen_r, 1'b1);
        gpio54_pkg::REG_HEN0: rd = gpio54_pkg::half_get(hen_r, 1'b0);
        gpio54_pkg::REG_HEN1: rd = gpio54_pkg::half_get(hen_r, 1'b1);
        gpio54_pkg::REG_LEN0: rd = gpio54_pkg::half_get(len_r, 1'b0);
        gpio54_pkg::REG_LEN1: rd = gpio54_pkg::half_get(len_r, 1'b1);
        gpio54_pkg::REG_PULL: rd = WW'(pull_ctrl_r);
        default: ;
      endcase
    end
  end

  assign ev = (ren_r & pins_in & ~level_r) | (fen_r & ~pins_in & level_r)
            | (hen_r & pins_in) | (len_r & ~pins_in);

  always_comb begin
    fsel_nxt = fsel_r;
    pull_set_nxt = pull_set_r;
    latch_nxt = latch_r;
    level_nxt = level_r;
    ren_nxt = ren_r;
    fen_nxt = fen_r;
    hen_nxt = hen_r;
    len_nxt = len_r;
    status_nxt = status_r;
    pull_ctrl_nxt = pull_ctrl_r;
    pull_sel = '0;
    if (in_fire && is_write) begin
      unique case (widx)
        gpio54_pkg::REG_SET0: latch_nxt = latch_r | gpio54_pkg::half_bits(wdata, 1'b0);
        gpio54_pkg::REG_SET1: latch_nxt = latch_r | gpio54_pkg::half_bits(wdata, 1'b1);
        gpio54_pkg::REG_CLR0: latch_nxt = latch_r & ~gpio54_pkg::half_bits(wdata, 1'b0);
        gpio54_pkg::REG_CLR1: latch_nxt = latch_r & ~gpio54_pkg::half_bits(wdata, 1'b1);
        gpio54_pkg::REG_EDS0: status_nxt = status_r & ~gpio54_pkg::half_bits(wdata, 1'b0);
        gpio54_pkg::REG_EDS1: status_nxt = status_r & ~gpio54_pkg::half_bits(wdata, 1'b1);
        gpio54_pkg::REG_REN0: ren_nxt = gpio54_pkg::half_put(ren_r, 1'b0, wdata);
        gpio54_pkg::REG_REN1: ren_nxt = gpio54_pkg::half_put(ren_r, 1'b1, wdata);
        gpio54_pkg::REG_FEN0: fen_nxt = gpio54_pkg::half_put(fen_r, 1'b0, wdata);
        gpio54_pkg::REG_FEN1: fen_nxt = gpio54_pkg::half_put(fen_r, 1'b1, wdata);
        gpio54_pkg::REG_HEN0: hen_nxt = gpio54_pkg::half_put(hen_r, 1'b0, wdata);
        gpio54_pkg::REG_HEN1: hen_nxt = gpio54_pkg::half_put(hen_r, 1'b1, wdata);
        gpio54_pkg::REG_LEN0: len_nxt = gpio54_pkg::half_put(len_r, 1'b0, wdata);
        gpio54_pkg::REG_LEN1: len_nxt = gpio54_pkg::half_put(len_r, 1'b1, wdata);
        gpio54_pkg::REG_PULL: pull_ctrl_nxt = wdata[PW-1:0];
        gpio54_pkg::REG_PULL_CLK0: pull_sel = gpio54_pkg::half_bits(wdata, 1'b0);
        gpio54_pkg::REG_PULL_CLK1: pull_sel = gpio54_pkg::half_bits(wdata, 1'b1);
        default: ;
      endcase
      for (int p = 0; p < PINS; p++) begin
        if (widx == IW'(p / gpio54_pkg::FSEL_PER_WORD)) begin
          fsel_nxt[p*FW +: FW] = wdata[FW*(p % gpio54_pkg::FSEL_PER_WORD) +: FW];
        end
        if (pull_sel[p]) begin
          pull_set_nxt[p*PW +: PW] = pull_ctrl_r;
        end
      end
    end else if (in_fire && mode == gpio54_pkg::MODE_TICK) begin
      status_nxt = status_r | ev;
      level_nxt = pins_in;
    end
  end

  always_comb begin
    for (int p = 0; p < PINS; p++) begin
      oe[p] = (fsel_nxt[p*FW +: FW] == gpio54_pkg::FSEL_OUTPUT);
      pu[p] = (pull_set_nxt[p*PW +: PW] == gpio54_pkg::PULL_UP);
      pd[p] = (pull_set_nxt[p*PW +: PW] == gpio54_pkg::PULL_DOWN);
    end
  end

  assign out_data_nxt = {(|status_nxt), pd, pu, oe, latch_nxt, rd};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsel_r <= '0;
      pull_set_r <= '0;
      latch_r <= '0;
      level_r <= '0;
      ren_r <= '0;
      fen_r <= '0;
      hen_r <= '0;
      len_r <= '0;
      status_r <= '0;
      pull_ctrl_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsel_r <= fsel_nxt;
      pull_set_r <= pull_set_nxt;
      latch_r <= latch_nxt;
      level_r <= level_nxt;
      ren_r <= ren_nxt;
      fen_r <= fen_nxt;
      hen_r <= hen_nxt;
      len_r <= len_nxt;
      status_r <= status_nxt;
      pull_ctrl_r <= pull_ctrl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = gpio54_pkg::OUT_TDATA_W'(out_data_r);

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input not ready while the output register is empty");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transfer produced no result");

  a_pull_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r[WW+2*PINS +: PINS] & out_data_r[WW+3*PINS +: PINS]) == '0))
    else $error("a pin drives both pull-up and pull-down");

  a_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[OUT_USED-1] == (|status_r)))
    else $error("event flag disagrees with event status");

endmodule

// File: sim/tb.sv
module tb;

  localparam int IX_LO = 0;
  localparam int WD_LO = gpio54_pkg::INDEX_W;
  localparam int LV_LO = gpio54_pkg::INDEX_W + gpio54_pkg::WORD_W;
  localparam int DRV_LO = gpio54_pkg::WORD_W;
  localparam int OE_LO = DRV_LO + gpio54_pkg::PIN_COUNT;
  localparam int PU_LO = OE_LO + gpio54_pkg::PIN_COUNT;
  localparam int PD_LO = PU_LO + gpio54_pkg::PIN_COUNT;
  localparam int EVT_BIT = PD_LO + gpio54_pkg::PIN_COUNT;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 850;
  localparam int PHASES = 6;

  localparam logic [gpio54_pkg::INDEX_W-1:0] FSEL_WORD0 = 6'd0;
  localparam logic [gpio54_pkg::INDEX_W-1:0] FSEL_WORD5 = 6'd5;
  localparam logic [gpio54_pkg::INDEX_W-1:0] UNMAPPED_TOP = 6'd63;
  localparam logic [gpio54_pkg::WORD_W-1:0] ALL_OUTPUTS = 32'h0924_9249;
  localparam logic [gpio54_pkg::WORD_W-1:0] ONES = 32'hffff_ffff;

  typedef struct packed {
    logic [gpio54_pkg::WORD_W-1:0] read_data;
    gpio54_pkg::pins_t             drive;
    gpio54_pkg::pins_t             oe;
    gpio54_pkg::pins_t             pu;
    gpio54_pkg::pins_t             pd;
    logic                          pending;
  } pin_report_t;

  class gpio_shadow_t;
    logic [gpio54_pkg::FSEL_W-1:0] fsel [gpio54_pkg::PIN_COUNT];
    logic [gpio54_pkg::PULL_W-1:0] pin_pull [gpio54_pkg::PIN_COUNT];
    logic [gpio54_pkg::PULL_W-1:0] pull_ctl;
    gpio54_pkg::pins_t latch, levels, status, rise_en, fall_en, high_en, low_en;
    pin_report_t reports [$];
    int errors;
    int seen;

    function new();
      for (int p = 0; p < gpio54_pkg::PIN_COUNT; p++) begin
        fsel[p] = '0;
        pin_pull[p] = '0;
      end
      pull_ctl = '0;
      latch = '0;
      levels = '0;
      status = '0;
      rise_en = '0;
      fall_en = '0;
      high_en = '0;
      low_en = '0;
      errors = 0;
      seen = 0;
    endfunction

    function logic [gpio54_pkg::WORD_W-1:0] word_of(gpio54_pkg::pins_t v, bit upper);
      logic [63:0] t;
      t = '0;
      t[gpio54_pkg::PIN_COUNT-1:0] = v;
      return upper ? t[63:32] : t[31:0];
    endfunction

    function gpio54_pkg::pins_t bits_of(logic [gpio54_pkg::WORD_W-1:0] d, bit upper);
      logic [63:0] t;
      t = upper ? {d, 32'h0} : {32'h0, d};
      return t[gpio54_pkg::PIN_COUNT-1:0];
    endfunction

    function gpio54_pkg::pins_t splice(gpio54_pkg::pins_t v, bit upper,
                                       logic [gpio54_pkg::WORD_W-1:0] d);
      logic [63:0] t;
      t = '0;
      t[gpio54_pkg::PIN_COUNT-1:0] = v;
      if (upper) begin
        t[63:32] = d;
      end else begin
        t[31:0] = d;
      end
      return t[gpio54_pkg::PIN_COUNT-1:0];
    endfunction

    function logic [gpio54_pkg::WORD_W-1:0] read_word(logic [gpio54_pkg::INDEX_W-1:0] w);
      logic [gpio54_pkg::WORD_W-1:0] r;
      int p;
      int k;
      r = '0;
      if (w <= gpio54_pkg::REG_FSEL_LAST) begin
        for (k = 0; k < gpio54_pkg::FSEL_PER_WORD; k++) begin
          p = int'(w) * gpio54_pkg::FSEL_PER_WORD + k;
          if (p < gpio54_pkg::PIN_COUNT) r[gpio54_pkg::FSEL_W*k +: gpio54_pkg::FSEL_W] = fsel[p];
        end
        return r;
      end
      unique case (w)
        gpio54_pkg::REG_LEV0, gpio54_pkg::REG_LEV1: begin
          r = word_of(levels, w == gpio54_pkg::REG_LEV1);
        end
        gpio54_pkg::REG_EDS0, gpio54_pkg::REG_EDS1: begin
          r = word_of(status, w == gpio54_pkg::REG_EDS1);
        end
        gpio54_pkg::REG_REN0, gpio54_pkg::REG_REN1: begin
          r = word_of(rise_en, w == gpio54_pkg::REG_REN1);
        end
        gpio54_pkg::REG_FEN0, gpio54_pkg::REG_FEN1: begin
          r = word_of(fall_en, w == gpio54_pkg::REG_FEN1);
        end
        gpio54_pkg::REG_HEN0, gpio54_pkg::REG_HEN1: begin
          r = word_of(high_en, w == gpio54_pkg::REG_HEN1);
        end
        gpio54_pkg::REG_LEN0, gpio54_pkg::REG_LEN1: begin
          r = word_of(low_en, w == gpio54_pkg::REG_LEN1);
        end
        gpio54_pkg::REG_PULL: r[gpio54_pkg::PULL_W-1:0] = pull_ctl;
        default: ;
      endcase
      return r;
    endfunction

    function void write_word(logic [gpio54_pkg::INDEX_W-1:0] w,
                             logic [gpio54_pkg::WORD_W-1:0] d);
      gpio54_pkg::pins_t sel;
      int p;
      int k;
      if (w <= gpio54_pkg::REG_FSEL_LAST) begin
        for (k = 0; k < gpio54_pkg::FSEL_PER_WORD; k++) begin
          p = int'(w) * gpio54_pkg::FSEL_PER_WORD + k;
          if (p < gpio54_pkg::PIN_COUNT) fsel[p] = d[gpio54_pkg::FSEL_W*k +: gpio54_pkg::FSEL_W];
        end
        return;
      end
      unique case (w)
        gpio54_pkg::REG_SET0, gpio54_pkg::REG_SET1: begin
          latch |= bits_of(d, w == gpio54_pkg::REG_SET1);
        end
        gpio54_pkg::REG_CLR0, gpio54_pkg::REG_CLR1: begin
          latch &= ~bits_of(d, w == gpio54_pkg::REG_CLR1);
        end
        gpio54_pkg::REG_EDS0, gpio54_pkg::REG_EDS1: begin
          status &= ~bits_of(d, w == gpio54_pkg::REG_EDS1);
        end
        gpio54_pkg::REG_REN0, gpio54_pkg::REG_REN1: begin
          rise_en = splice(rise_en, w == gpio54_pkg::REG_REN1, d);
        end
        gpio54_pkg::REG_FEN0, gpio54_pkg::REG_FEN1: begin
          fall_en = splice(fall_en, w == gpio54_pkg::REG_FEN1, d);
        end
        gpio54_pkg::REG_HEN0, gpio54_pkg::REG_HEN1: begin
          high_en = splice(high_en, w == gpio54_pkg::REG_HEN1, d);
        end
        gpio54_pkg::REG_LEN0, gpio54_pkg::REG_LEN1: begin
          low_en = splice(low_en, w == gpio54_pkg::REG_LEN1, d);
        end
        gpio54_pkg::REG_PULL: pull_ctl = d[gpio54_pkg::PULL_W-1:0];
        gpio54_pkg::REG_PULL_CLK0, gpio54_pkg::REG_PULL_CLK1: begin
          sel = bits_of(d, w == gpio54_pkg::REG_PULL_CLK1);
          for (p = 0; p < gpio54_pkg::PIN_COUNT; p++) begin
            if (sel[p]) pin_pull[p] = pull_ctl;
          end
        end
        default: ;
      endcase
    endfunction

    function void apply_access(gpio54_pkg::mode_t m, logic [gpio54_pkg::INDEX_W-1:0] w,
                               logic [gpio54_pkg::WORD_W-1:0] d, gpio54_pkg::pins_t lev);
      pin_report_t r;
      r = '0;
      unique case (m)
        gpio54_pkg::MODE_READ: r.read_data = read_word(w);
        gpio54_pkg::MODE_WRITE: write_word(w, d);
        gpio54_pkg::MODE_TICK: begin
          status |= (rise_en & lev & ~levels) | (fall_en & ~lev & levels) |
                    (high_en & lev) | (low_en & ~lev);
          levels = lev;
        end
        default: ;
      endcase
      for (int p = 0; p < gpio54_pkg::PIN_COUNT; p++) begin
        r.oe[p] = (fsel[p] == gpio54_pkg::FSEL_OUTPUT);
        r.pu[p] = (pin_pull[p] == gpio54_pkg::PULL_UP);
        r.pd[p] = (pin_pull[p] == gpio54_pkg::PULL_DOWN);
      end
      r.drive = latch;
      r.pending = |status;
      reports.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch in %s of result %0d: got %h, expected %h", what, seen, got, want);
      errors++;
    endtask

    task compare_report(pin_report_t got);
      pin_report_t want;
      if (reports.size() == 0) begin
        report("unexpected result", 64'(got.read_data), '0);
      end else begin
        want = reports.pop_front();
        if (got.read_data !== want.read_data)
          report("read_data", 64'(got.read_data), 64'(want.read_data));
        if (got.drive !== want.drive) report("drive_levels", 64'(got.drive), 64'(want.drive));
        if (got.oe !== want.oe) report("output_enable", 64'(got.oe), 64'(want.oe));
        if (got.pu !== want.pu) report("pull_up_enable", 64'(got.pu), 64'(want.pu));
        if (got.pd !== want.pd) report("pull_down_enable", 64'(got.pd), 64'(want.pd));
        if (got.pending !== want.pending)
          report("event_pending", 64'(got.pending), 64'(want.pending));
      end
      seen++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [gpio54_pkg::IN_TDATA_W-1:0] in_tdata;
  logic [gpio54_pkg::MODE_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [gpio54_pkg::OUT_TDATA_W-1:0] out_tdata;

  gpio_shadow_t shadow = new();
  bit steady;
  bit hold_req;
  int cycles = 0;
  gpio54_pkg::pins_t last_lev;
  logic [gpio54_pkg::INDEX_W-1:0] mapped_words [20] = '{
      gpio54_pkg::REG_SET0, gpio54_pkg::REG_SET1, gpio54_pkg::REG_CLR0,
      gpio54_pkg::REG_CLR1, gpio54_pkg::REG_LEV0, gpio54_pkg::REG_LEV1,
      gpio54_pkg::REG_EDS0, gpio54_pkg::REG_EDS1, gpio54_pkg::REG_REN0,
      gpio54_pkg::REG_REN1, gpio54_pkg::REG_FEN0, gpio54_pkg::REG_FEN1,
      gpio54_pkg::REG_HEN0, gpio54_pkg::REG_HEN1, gpio54_pkg::REG_LEN0,
      gpio54_pkg::REG_LEN1, gpio54_pkg::REG_PULL, gpio54_pkg::REG_PULL_CLK0,
      gpio54_pkg::REG_PULL_CLK1, gpio54_pkg::REG_FSEL_LAST};

  gpio_controller_54_pin dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(gpio54_pkg::mode_t m, logic [gpio54_pkg::INDEX_W-1:0] w,
                           logic [gpio54_pkg::WORD_W-1:0] d, gpio54_pkg::pins_t lev);
    logic [gpio54_pkg::IN_TDATA_W-1:0] t;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    t = '0;
    t[IX_LO +: gpio54_pkg::INDEX_W] = w;
    t[WD_LO +: gpio54_pkg::WORD_W] = d;
    t[LV_LO +: gpio54_pkg::PIN_COUNT] = lev;
    in_tvalid <= 1'b1;
    in_tuser <= m;
    in_tdata <= t;
    do @(posedge clk); while (!in_tready);
    shadow.apply_access(m, w, d, lev);
    @(negedge clk);
  endtask

  function automatic logic [gpio54_pkg::WORD_W-1:0] rand_word(
      logic [gpio54_pkg::INDEX_W-1:0] w);
    logic [gpio54_pkg::WORD_W-1:0] d;
    int k;
    k = $urandom_range(0, 9);
    d = $urandom;
    if (k == 0) d = ONES;
    else if (k == 1) d = '0;
    else if (k == 2) d = 32'h1 << $urandom_range(0, 31);
    else if (k < 6 && w <= gpio54_pkg::REG_FSEL_LAST) begin
      for (int f = 0; f < gpio54_pkg::FSEL_PER_WORD; f++) begin
        if ($urandom_range(0, 3) != 0) begin
          d[gpio54_pkg::FSEL_W*f +: gpio54_pkg::FSEL_W] = gpio54_pkg::FSEL_OUTPUT;
        end
      end
    end
    return d;
  endfunction

  function automatic gpio54_pkg::pins_t rand_levels();
    gpio54_pkg::pins_t v;
    gpio54_pkg::pins_t m1;
    gpio54_pkg::pins_t m2;
    int k;
    k = $urandom_range(0, 9);
    v = gpio54_pkg::PIN_COUNT'({$urandom, $urandom});
    m1 = gpio54_pkg::PIN_COUNT'({$urandom, $urandom});
    m2 = gpio54_pkg::PIN_COUNT'({$urandom, $urandom});
    if (k == 0) return '0;
    if (k == 1) return '1;
    if (k < 6) return last_lev ^ (v & m1 & m2);
    return v;
  endfunction

  task automatic send_random();
    gpio54_pkg::mode_t m;
    logic [gpio54_pkg::INDEX_W-1:0] w;
    gpio54_pkg::pins_t lev;
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) m = gpio54_pkg::MODE_READ;
    else if (r < 63) m = gpio54_pkg::MODE_WRITE;
    else if (r < 95) m = gpio54_pkg::MODE_TICK;
    else m = gpio54_pkg::MODE_NOP;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      w = gpio54_pkg::INDEX_W'($urandom_range(0, int'(gpio54_pkg::REG_FSEL_LAST)));
    end else if (r < 85) begin
      w = mapped_words[$urandom_range(0, 19)];
    end else begin
      w = gpio54_pkg::INDEX_W'($urandom_range(0, 63));
    end
    lev = rand_levels();
    if (m == gpio54_pkg::MODE_TICK) last_lev = lev;
    send_item(m, w, rand_word(w), lev);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      shadow.compare_report({out_tdata[DRV_LO-1:0],
                             out_tdata[DRV_LO +: gpio54_pkg::PIN_COUNT],
                             out_tdata[OE_LO +: gpio54_pkg::PIN_COUNT],
                             out_tdata[PU_LO +: gpio54_pkg::PIN_COUNT],
                             out_tdata[PD_LO +: gpio54_pkg::PIN_COUNT],
                             out_tdata[EVT_BIT]});
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int stall;
    stall = 0;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        stall = pick_gap();
        out_tready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin
    steady = 1'b0;
    hold_req = 1'b0;
    last_lev = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = gpio54_pkg::MODE_READ;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(gpio54_pkg::MODE_READ, FSEL_WORD0, '0, '0);
    send_item(gpio54_pkg::MODE_WRITE, FSEL_WORD0, ONES, '0);
    send_item(gpio54_pkg::MODE_READ, FSEL_WORD0, '0, '1);
    send_item(gpio54_pkg::MODE_WRITE, FSEL_WORD5, ALL_OUTPUTS, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_FSEL_LAST, ONES, '0);
    send_item(gpio54_pkg::MODE_READ, FSEL_WORD5, '0, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_SET0, ONES, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_SET1, ONES, '0);
    send_item(gpio54_pkg::MODE_READ, gpio54_pkg::REG_SET1, '0, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_CLR1, 32'h0000_0f0f, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_LEV0, ONES, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_REN0, ONES, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_FEN1, ONES, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_HEN1, 32'h0020_0000, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_LEN0, 32'h8000_0000, '0);
    send_item(gpio54_pkg::MODE_TICK, gpio54_pkg::REG_LEV0, '0, '1);
    send_item(gpio54_pkg::MODE_TICK, gpio54_pkg::REG_LEV0, '0, '0);
    send_item(gpio54_pkg::MODE_READ, gpio54_pkg::REG_EDS1, '0, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_EDS0, ONES, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_PULL, 32'h3, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_PULL_CLK0, ONES, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_PULL, ONES, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_PULL_CLK1, ONES, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_PULL, 32'h1, '0);
    send_item(gpio54_pkg::MODE_WRITE, gpio54_pkg::REG_PULL_CLK0, 32'h5555_5555, '0);
    send_item(gpio54_pkg::MODE_NOP, gpio54_pkg::REG_PULL, ONES, '1);
    send_item(gpio54_pkg::MODE_READ, UNMAPPED_TOP, '0, '0);
    send_item(gpio54_pkg::MODE_WRITE, UNMAPPED_TOP, ONES, '0);

    for (int ph = 0; ph < PHASES; ph++) begin
      steady = (ph == 1 || ph == 3);
      if (ph == 3) hold_req = 1'b1;
      repeat (RANDOM_ITEMS / PHASES + 1) send_random();
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (shadow.reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/gpio54_pkg.sv
hdl/gpio_controller_54_pin.sv
sim/tb.sv
